// ===== rtl/terminal_text_filter_wrap_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the terminal text filter
// Concurrent assertion wrappers clocked on clk.
// ---------------------------------------------------------------------------
`ifndef TERMINAL_TEXT_FILTER_WRAP_MACROS_SVH
`define TERMINAL_TEXT_FILTER_WRAP_MACROS_SVH

// Checked only while out of reset
`define TTFW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define TTFW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ttfw_pkg.sv =====
// ---------------------------------------------------------------------------
// ttfw_pkg
// Constants shared by the terminal text filter and its checker.
// ---------------------------------------------------------------------------
package ttfw_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned PhaseW = 2;
  localparam int unsigned RemW   = 2;

  localparam logic [ByteW-1:0] CH_TAB      = 8'h09;
  localparam logic [ByteW-1:0] CH_LF       = 8'h0a;
  localparam logic [ByteW-1:0] CH_CR       = 8'h0d;
  localparam logic [ByteW-1:0] CH_ESC      = 8'h1b;
  localparam logic [ByteW-1:0] CH_SPACE    = 8'h20;
  localparam logic [ByteW-1:0] CH_LBRACKET = 8'h5b;
  localparam logic [ByteW-1:0] CH_DEL      = 8'h7f;
  localparam logic [ByteW-1:0] CSI_FIN_LO  = 8'h40;
  localparam logic [ByteW-1:0] CSI_FIN_HI  = 8'h7e;
  localparam logic [ByteW-1:0] COL_MAX     = 8'hff;

  localparam logic [ByteW-1:0] WRAP_COL_RST = 8'd80;

  localparam logic [PhaseW-1:0] PH_IDLE = 2'd0;
  localparam logic [PhaseW-1:0] PH_ESC  = 2'd1;
  localparam logic [PhaseW-1:0] PH_CSI  = 2'd2;

endpackage

// ===== rtl/terminal_text_filter_wrap.sv =====
// Latency: results of a byte appear on the output the cycle after it is taken.
// Throughput: one input byte per cycle while out_tready is high; a byte that gives
//   two or three output bytes (CR LF, or a wrap) holds the input until the
//   slot registers have drained, one byte per cycle while out_tready is high.
// Reset: synchronous, active low; column 0, no escape pending, line width 80.
// ---------------------------------------------------------------------------
// terminal_text_filter_wrap
// Strips ANSI CSI sequences, lone ESC and control bytes, expands CR/LF to
// CR LF and wraps lines at a programmable width.
// ---------------------------------------------------------------------------
module terminal_text_filter_wrap (
  input  logic                       clk,
  input  logic                       rst_n,
  // config
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [ttfw_pkg::ByteW-1:0] cfg_data,    // [7:0] wrap column
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [ttfw_pkg::ByteW-1:0] in_tdata,    // [7:0] in_byte
  input  logic                       in_tlast,    // buffer_end
  // output stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [ttfw_pkg::ByteW-1:0] out_tdata,   // [7:0] out_byte
  output logic                       out_tlast    // last
);

  logic [ttfw_pkg::ByteW-1:0]  wrap_col_r;
  logic [ttfw_pkg::ByteW-1:0]  column_r, column_nxt;
  logic [ttfw_pkg::PhaseW-1:0] phase_r, phase_nxt;
  logic [ttfw_pkg::ByteW-1:0]  slot0_r, slot1_r, slot2_r;
  logic [ttfw_pkg::ByteW-1:0]  slot0_nxt, slot1_nxt, slot2_nxt;
  logic [ttfw_pkg::RemW-1:0]   rem_r, rem_nxt;

  logic [ttfw_pkg::ByteW-1:0]  new0, new1, new2;
  logic [ttfw_pkg::RemW-1:0]   new_cnt;
  logic [ttfw_pkg::ByteW-1:0]  ch;
  logic                        plain, printable, wrap;
  logic                        in_fire, out_fire;

  assign cfg_ready  = 1'b1;
  assign out_tvalid = (rem_r != '0);
  assign out_tdata  = slot0_r;
  assign out_tlast  = (rem_r == ttfw_pkg::RemW'(1));
  assign out_fire   = out_tvalid && out_tready;
  assign in_tready  = (rem_r == '0) || (out_tlast && out_tready);
  assign in_fire    = in_tvalid && in_tready;

  always_comb begin
    plain = (phase_r == ttfw_pkg::PH_ESC) ? (in_tdata != ttfw_pkg::CH_LBRACKET)
                                          : (phase_r != ttfw_pkg::PH_CSI);
    ch        = (in_tdata == ttfw_pkg::CH_TAB) ? ttfw_pkg::CH_SPACE : in_tdata;
    printable = (in_tdata == ttfw_pkg::CH_TAB) ||
                ((in_tdata >= ttfw_pkg::CH_SPACE) && (in_tdata != ttfw_pkg::CH_DEL));
    wrap      = (wrap_col_r != '0) && (column_r >= wrap_col_r);

    new0       = ch;
    new1       = ch;
    new2       = ch;
    new_cnt    = '0;
    column_nxt = column_r;
    phase_nxt  = phase_r;

    if (phase_r == ttfw_pkg::PH_ESC && !plain) begin
      phase_nxt = ttfw_pkg::PH_CSI;
    end else if (!plain) begin
      if (in_tdata >= ttfw_pkg::CSI_FIN_LO && in_tdata <= ttfw_pkg::CSI_FIN_HI) begin
        phase_nxt = ttfw_pkg::PH_IDLE;
      end
    end else begin
      phase_nxt = ttfw_pkg::PH_IDLE;
      priority if (in_tdata == ttfw_pkg::CH_ESC) begin
        phase_nxt = ttfw_pkg::PH_ESC;
      end else if (in_tdata == ttfw_pkg::CH_CR || in_tdata == ttfw_pkg::CH_LF) begin
        new0       = ttfw_pkg::CH_CR;
        new1       = ttfw_pkg::CH_LF;
        new_cnt    = ttfw_pkg::RemW'(2);
        column_nxt = '0;
      end else if (printable && wrap) begin
        new0       = ttfw_pkg::CH_CR;
        new1       = ttfw_pkg::CH_LF;
        new_cnt    = ttfw_pkg::RemW'(3);
        column_nxt = ttfw_pkg::ByteW'(1);
      end else if (printable) begin
        new_cnt    = ttfw_pkg::RemW'(1);
        column_nxt = (column_r == ttfw_pkg::COL_MAX) ? column_r
                                                     : ttfw_pkg::ByteW'(column_r + 8'd1);
      end else begin
        new_cnt = '0;
      end
    end

    if (in_tlast) begin
      phase_nxt = ttfw_pkg::PH_IDLE;
    end
  end

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    slot2_nxt = slot2_r;
    rem_nxt   = rem_r;
    if (in_fire) begin
      slot0_nxt = new0;
      slot1_nxt = new1;
      slot2_nxt = new2;
      rem_nxt   = new_cnt;
    end else if (out_fire) begin
      slot0_nxt = slot1_r;
      slot1_nxt = slot2_r;
      rem_nxt   = rem_r - ttfw_pkg::RemW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_col_r <= ttfw_pkg::WRAP_COL_RST;
      column_r   <= '0;
      phase_r    <= ttfw_pkg::PH_IDLE;
      rem_r      <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        wrap_col_r <= cfg_data;
      end
      if (in_fire) begin
        column_r <= column_nxt;
        phase_r  <= phase_nxt;
      end
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
    slot2_r <= slot2_nxt;
  end

endmodule

// ===== rtl/ttfw_checker.sv =====
// ---------------------------------------------------------------------------
// ttfw_checker
// Port-level checks on the terminal text filter, bound to the top level.
// ---------------------------------------------------------------------------
`include "terminal_text_filter_wrap_macros.svh"

module ttfw_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [ttfw_pkg::ByteW-1:0] out_tdata,
  input logic                       out_tlast
);

  logic                     out_stall;
  logic [ttfw_pkg::ByteW:0] out_word;

  assign out_stall = out_tvalid && !out_tready;
  assign out_word  = {out_tlast, out_tdata};

  `TTFW_ASSERT(a_out_hold, out_stall |=> out_tvalid && $stable(out_word), "held output changed")
  `TTFW_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "output valid right after reset")
  `TTFW_ASSERT(a_idle_ready, !out_tvalid |-> in_tready, "input stalled with empty output")
  `TTFW_ASSERT(a_mid_block, out_tvalid && !out_tlast |-> !in_tready, "input taken mid-burst")

endmodule

bind terminal_text_filter_wrap ttfw_checker u_ttfw_checker (.*);
